### sv/pci_pkg.sv
package pci_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned XW = 40;
  localparam int unsigned ZW = 34;
  localparam logic [29:0] KinvQ30 = 30'd652032874;
  localparam logic [16:0] OneQ16 = 17'd65536;
  localparam logic signed [ZW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HalfTurn = 34'sd2147483648;

  typedef struct packed {
    logic [15:0] mag_a;
    logic signed [15:0] phase_a;
    logic [15:0] mag_b;
    logic signed [15:0] phase_b;
  } in_t;

  typedef struct packed {
    logic [15:0] mag_out;
    logic signed [15:0] phase_out;
  } out_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10680862;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/polar_complex_interpolate_top.sv
// throughput: one transaction per cycle; a stall freezes the whole pipeline
// stages: 2 scale, cordic_steps rotation, 3 mix, 1 prep, cordic_steps vectoring, 2 output
// rst_ni low clears all valid bits and mix_weight to 0
module polar_complex_interpolate_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pci_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pci_pkg::out_t   out_data_o,
  input  logic            cfg_we_i,
  input  logic [16:0]     cfg_wdata_i
);
  localparam int unsigned N = pci_pkg::CordicSteps;
  localparam int unsigned XW = pci_pkg::XW;
  localparam int unsigned ZW = pci_pkg::ZW;
  localparam int unsigned NS = 2 * N + 8;

  logic adv;
  logic [NS-1:0] v_q;
  logic [16:0] w_q;

  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      w_q <= '0;
    end else begin
      if (cfg_we_i) begin
        w_q <= (cfg_wdata_i > pci_pkg::OneQ16) ? pci_pkg::OneQ16 : cfg_wdata_i;
      end
      if (adv) begin
        v_q <= {v_q[NS-2:0], in_valid_i};
      end
    end
  end

  // stage s0: scale magnitudes by 1/K
  logic [45:0] pa_q, pb_q;
  logic signed [ZW-1:0] za0_q, zb0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q <= 46'(in_data_i.mag_a) * 46'(pci_pkg::KinvQ30);
      pb_q <= 46'(in_data_i.mag_b) * 46'(pci_pkg::KinvQ30);
      za0_q <= ZW'(in_data_i.phase_a) <<< 16;
      zb0_q <= ZW'(in_data_i.phase_b) <<< 16;
    end
  end

  // stage s1: quadrant fold
  logic signed [XW-1:0] xa_q [0:N], ya_q [0:N], xb_q [0:N], yb_q [0:N];
  logic signed [ZW-1:0] za_q [0:N], zb_q [0:N];
  always_ff @(posedge clk_i) begin
    logic signed [XW-1:0] xa, xb;
    logic signed [ZW-1:0] za, zb;
    if (adv) begin
      xa = XW'(pa_q[45:16]);
      xb = XW'(pb_q[45:16]);
      za = za0_q;
      zb = zb0_q;
      if (za > pci_pkg::QuarterTurn) begin
        za = za - pci_pkg::HalfTurn; xa = -xa;
      end else if (za < -pci_pkg::QuarterTurn) begin
        za = za + pci_pkg::HalfTurn; xa = -xa;
      end
      if (zb > pci_pkg::QuarterTurn) begin
        zb = zb - pci_pkg::HalfTurn; xb = -xb;
      end else if (zb < -pci_pkg::QuarterTurn) begin
        zb = zb + pci_pkg::HalfTurn; xb = -xb;
      end
      xa_q[0] <= xa; ya_q[0] <= '0; za_q[0] <= za;
      xb_q[0] <= xb; yb_q[0] <= '0; zb_q[0] <= zb;
    end
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (za_q[i] >= 0) begin
          xa_q[i+1] <= xa_q[i] - (ya_q[i] >>> i);
          ya_q[i+1] <= ya_q[i] + (xa_q[i] >>> i);
          za_q[i+1] <= za_q[i] - pci_pkg::atan_turn(i);
        end else begin
          xa_q[i+1] <= xa_q[i] + (ya_q[i] >>> i);
          ya_q[i+1] <= ya_q[i] - (xa_q[i] >>> i);
          za_q[i+1] <= za_q[i] + pci_pkg::atan_turn(i);
        end
        if (zb_q[i] >= 0) begin
          xb_q[i+1] <= xb_q[i] - (yb_q[i] >>> i);
          yb_q[i+1] <= yb_q[i] + (xb_q[i] >>> i);
          zb_q[i+1] <= zb_q[i] - pci_pkg::atan_turn(i);
        end else begin
          xb_q[i+1] <= xb_q[i] + (yb_q[i] >>> i);
          yb_q[i+1] <= yb_q[i] - (xb_q[i] >>> i);
          zb_q[i+1] <= zb_q[i] + pci_pkg::atan_turn(i);
        end
      end
    end
  end

  // mix: products, sum, round
  logic signed [XW+17:0] mar_q, mai_q, mbr_q, mbi_q;
  logic signed [XW+18:0] sr_q, si_q;
  logic signed [XW-1:0] re_q, im_q;
  always_ff @(posedge clk_i) begin
    logic signed [17:0] wa, wb;
    if (adv) begin
      wb = $signed({1'b0, w_q});
      wa = $signed({1'b0, pci_pkg::OneQ16 - w_q});
      mar_q <= (XW+18)'(wa) * (XW+18)'(xa_q[N]);
      mai_q <= (XW+18)'(wa) * (XW+18)'(ya_q[N]);
      mbr_q <= (XW+18)'(wb) * (XW+18)'(xb_q[N]);
      mbi_q <= (XW+18)'(wb) * (XW+18)'(yb_q[N]);
      sr_q <= (XW+19)'(mar_q) + (XW+19)'(mbr_q) + (XW+19)'(32768);
      si_q <= (XW+19)'(mai_q) + (XW+19)'(mbi_q) + (XW+19)'(32768);
      re_q <= XW'(sr_q >>> 16);
      im_q <= XW'(si_q >>> 16);
    end
  end

  // vectoring prep
  logic signed [XW:0] vx_q [0:N], vy_q [0:N];
  logic signed [ZW-1:0] vz_q [0:N];
  logic vzero_q [0:N+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vzero_q[0] <= (re_q == 0) && (im_q == 0);
      if (re_q < 0) begin
        if (im_q >= 0) begin
          vx_q[0] <= (XW+1)'(im_q); vy_q[0] <= -(XW+1)'(re_q);
          vz_q[0] <= pci_pkg::QuarterTurn;
        end else begin
          vx_q[0] <= -(XW+1)'(im_q); vy_q[0] <= (XW+1)'(re_q);
          vz_q[0] <= -pci_pkg::QuarterTurn;
        end
      end else begin
        vx_q[0] <= (XW+1)'(re_q); vy_q[0] <= (XW+1)'(im_q); vz_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vzero_q[i+1] <= vzero_q[i];
        if (vy_q[i] >= 0) begin
          vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] + pci_pkg::atan_turn(i);
        end else begin
          vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] - pci_pkg::atan_turn(i);
        end
      end
    end
  end

  // output: gain correction multiply, then saturate
  logic [XW+29:0] m_q;
  logic [15:0] ph_q;
  pci_pkg::out_t o_q;
  always_ff @(posedge clk_i) begin
    logic signed [ZW:0] zr;
    logic [XW+29:0] mr;
    if (adv) begin
      vzero_q[N+1] <= vzero_q[N];
      m_q <= (vx_q[N] < 0) ? '0 :
             (XW+30)'(vx_q[N][XW-1:0]) * (XW+30)'(pci_pkg::KinvQ30);
      zr = (ZW+1)'(vz_q[N]) + (ZW+1)'(32768);
      ph_q <= zr[31:16];
      mr = (m_q + ((XW+30)'(1) << 43)) >> 44;
      if (vzero_q[N+1]) begin
        o_q.mag_out <= '0;
        o_q.phase_out <= '0;
      end else begin
        o_q.mag_out <= (mr > (XW+30)'(65535)) ? 16'hFFFF : mr[15:0];
        o_q.phase_out <= ph_q;
      end
    end
  end

  assign out_data_o = o_q;

endmodule
